// ----- src/bawm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the byte-addressable word memory.
package bawm_pkg;

	// Access direction codes
	localparam logic ACTION_READ  = 1'b0;
	localparam logic ACTION_WRITE = 1'b1;

	// Access size codes (the unused code behaves as a word)
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	// Byte-of-access masks per size
	localparam logic [3:0] MASK_BYTE = 4'b0001;
	localparam logic [3:0] MASK_HALF = 4'b0011;
	localparam logic [3:0] MASK_WORD = 4'b1111;

	typedef struct packed {
		logic        action;
		logic [1:0]  access_size;
		logic [31:0] byte_address;
		logic [31:0] write_value;
	} req_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        out_of_range;
	} rsp_t;

endpackage

// ----- src/bawm_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module bawm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write, and register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/byte_addressable_word_memory.sv -----
`timescale 1ns / 1ps
// Top level of the byte-addressable, little-endian word memory.
// Little-endian byte-addressed memory of 32-bit words, taking one read or write transaction
// of 1, 2 or 4 bytes at any alignment per cycle, unless clearing or a stalled response
// holds it. Words sit in two banks (even and odd word index), each made of four byte-wide
// single-port RAMs, so an unaligned access that spans two words reaches both in the same
// cycle. A request passes the input, RAM read and result registers. Any access with a byte
// at or beyond MEMORY_BYTES writes nothing and returns out_of_range with zero data; writes
// return zero data. After reset the block clears every word of both banks, one of each per
// cycle, and takes no request meanwhile.
module byte_addressable_word_memory #(
	parameter int MEMORY_BYTES = 65536
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bawm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bawm_pkg::rsp_t rsp
);

	import bawm_pkg::*;

	localparam int STORE_WORDS = (MEMORY_BYTES + 3) / 4;
	localparam int BANK_WORDS  = (STORE_WORDS + 1) / 2;
	localparam int BW          = $clog2(BANK_WORDS);

	// Clearing pass
	logic          clr_busy_q;
	logic [BW-1:0] clr_idx_q;

	// Pipeline registers
	logic          v_s1;
	req_t          req_s1;
	logic          v_s2;
	logic          rd_s2;
	logic          err_s2;
	logic [1:0]    off_s2;
	logic          par_s2;
	logic [3:0]    mask_s2;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// Flow control
	logic adv3, free2, mv1, free1;

	// Stage 1 decode
	logic [3:0]          mask;
	logic [32:0]         end_addr;
	logic                err;
	logic [BW:0]         wi;
	logic [BW-1:0]       half_idx;
	logic [BW-1:0]       even_idx;
	logic [1:0]          off;
	logic [1:0][3:0]     ram_we;
	logic [1:0][BW-1:0]  ram_addr;
	logic [3:0][7:0]     lane_wdata;
	logic [1:0][3:0][7:0] ram_rdata;
	logic [31:0]         rd_word;

	assign adv3  = !rsp_valid_q || rsp_ready;
	assign free2 = !v_s2 || adv3;
	assign mv1   = v_s1 && free2;
	assign free1 = !v_s1 || free2;
	assign req_ready = !clr_busy_q && free1;

	// Decode the access held in stage 1
	always_comb begin
		unique case (req_s1.access_size)
			SIZE_BYTE: mask = MASK_BYTE;
			SIZE_HALF: mask = MASK_HALF;
			default:   mask = MASK_WORD;
		endcase
	end

	assign end_addr = {1'b0, req_s1.byte_address} + {29'd0, 4'(mask[3] ? 4 : (mask[1] ? 2 : 1))};
	assign err      = end_addr > 33'(MEMORY_BYTES);
	assign wi       = req_s1.byte_address[BW+2:2];
	assign off      = req_s1.byte_address[1:0];
	assign half_idx = wi[BW:1];
	assign even_idx = half_idx + BW'(wi[0]);

	// Steer each byte lane to its bank and pick its write byte
	always_comb begin
		logic [1:0] lane;
		logic [1:0] k;
		logic       bank;
		ram_we     = '0;
		lane_wdata = '0;
		for (int l = 0; l < 4; l++) begin
			lane = 2'(l);
			k    = lane - off;
			bank = wi[0] ^ (lane < off);
			lane_wdata[l] = req_s1.write_value[8*k +: 8];
			if (mv1 && req_s1.action == ACTION_WRITE && !err && mask[k]) begin
				ram_we[bank][l] = 1'b1;
			end
		end
		// Clearing pass overrides: zero every lane of both banks
		if (clr_busy_q) begin
			ram_we     = '1;
			lane_wdata = '0;
		end
	end

	assign ram_addr[0] = clr_busy_q ? clr_idx_q : even_idx;
	assign ram_addr[1] = clr_busy_q ? clr_idx_q : half_idx;

	// Two banks of four byte-wide RAMs
	for (genvar b = 0; b < 2; b++) begin : g_bank
		for (genvar l = 0; l < 4; l++) begin : g_lane
			bawm_ram #(
				.WIDTH(8),
				.DEPTH(BANK_WORDS)
			) u_ram (
				.clk  (clk),
				.we   (ram_we[b][l]),
				.re   (mv1),
				.addr (ram_addr[b]),
				.wdata(lane_wdata[l]),
				.rdata(ram_rdata[b][l])
			);
		end
	end

	// Gather the read bytes back into access order
	always_comb begin
		logic [1:0] lane;
		logic       bank;
		rd_word = '0;
		for (int k = 0; k < 4; k++) begin
			lane = off_s2 + 2'(k);
			bank = par_s2 ^ (lane < off_s2);
			if (mask_s2[k]) begin
				rd_word[8*k +: 8] = ram_rdata[bank][lane];
			end
		end
	end

	// Advance the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == BW'(BANK_WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (free1) begin
				v_s1 <= req_valid && !clr_busy_q;
			end
			if (free2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				rsp_valid_q <= v_s2;
			end
		end
	end

	// Pipeline payload: hold while stalled
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (mv1) begin
			rd_s2   <= (req_s1.action == ACTION_READ);
			err_s2  <= err;
			off_s2  <= off;
			par_s2  <= wi[0];
			mask_s2 <= mask;
		end
		if (v_s2 && adv3) begin
			rsp_q.read_value   <= (rd_s2 && !err_s2) ? rd_word : 32'd0;
			rsp_q.out_of_range <= err_s2;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- sim/tb_byte_addressable_word_memory.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the byte-addressable word memory: table of cases, then random traffic.
module tb_byte_addressable_word_memory;
	import bawm_pkg::*;

	localparam int MEMORY_BYTES = 65536;
	localparam int STORE_WORDS  = (MEMORY_BYTES + 3) / 4;
	localparam int WORD_BITS    = $clog2(STORE_WORDS);
	localparam int RANDOM_ITEMS = 1350;
	localparam int HOLD_CYCLES  = 48;
	localparam int IDLE_LIMIT   = 40000;
	localparam int REPORT_LIMIT = 40;
	localparam int SETTLE_CYCLES = 8;

	// Size code left undefined by the package; the block treats it as a word
	localparam logic [1:0] SIZE_UNDEFINED = 2'd3;

	// Where a table row takes its expected response from
	localparam logic FROM_TABLE = 1'b1;
	localparam logic FROM_MODEL = 1'b0;

	typedef struct packed {
		logic        action;
		logic [1:0]  size;
		logic [31:0] addr;
		logic [31:0] data;
		logic        source;
		logic [31:0] read_value;
		logic        out_of_range;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 24;

	// Directed cases, in order; rows marked FROM_MODEL are checked against the shadow store
	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{ACTION_READ,  SIZE_WORD,      32'h0000_0000, 32'h0000_0000, FROM_TABLE, 32'h0, 1'b0},
		'{ACTION_READ,  SIZE_WORD,      32'h0000_FFFC, 32'h0000_0000, FROM_TABLE, 32'h0, 1'b0},
		'{ACTION_WRITE, SIZE_WORD,      32'h0000_0000, 32'hFFFF_FFFF, FROM_TABLE, 32'h0, 1'b0},
		'{ACTION_READ,  SIZE_BYTE,      32'h0000_0000, 32'h0000_0000, FROM_MODEL, 32'h0, 1'b0},
		'{ACTION_WRITE, SIZE_HALF,      32'h0000_0001, 32'h0000_A55A, FROM_TABLE, 32'h0, 1'b0},
		'{ACTION_READ,  SIZE_WORD,      32'h0000_0000, 32'h0000_0000, FROM_MODEL, 32'h0, 1'b0},
		'{ACTION_WRITE, SIZE_WORD,      32'h0000_0003, 32'h1234_5678, FROM_TABLE, 32'h0, 1'b0},
		'{ACTION_READ,  SIZE_WORD,      32'h0000_0002, 32'h0000_0000, FROM_MODEL, 32'h0, 1'b0},
		'{ACTION_WRITE, SIZE_UNDEFINED, 32'h0000_0006, 32'hDEAD_BEEF, FROM_TABLE, 32'h0, 1'b0},
		'{ACTION_READ,  SIZE_UNDEFINED, 32'h0000_0005, 32'h0000_0000, FROM_MODEL, 32'h0, 1'b0},
		'{ACTION_WRITE, SIZE_BYTE,      32'h0000_FFFF, 32'hFFFF_FF80, FROM_TABLE, 32'h0, 1'b0},
		'{ACTION_READ,  SIZE_BYTE,      32'h0000_FFFF, 32'h0000_0000, FROM_MODEL, 32'h0, 1'b0},
		'{ACTION_WRITE, SIZE_HALF,      32'h0000_FFFF, 32'h0000_FFFF, FROM_TABLE, 32'h0, 1'b1},
		'{ACTION_READ,  SIZE_HALF,      32'h0000_FFFE, 32'h0000_0000, FROM_MODEL, 32'h0, 1'b0},
		'{ACTION_READ,  SIZE_WORD,      32'h0000_FFFD, 32'h0000_0000, FROM_TABLE, 32'h0, 1'b1},
		'{ACTION_READ,  SIZE_WORD,      32'h0000_FFFC, 32'h0000_0000, FROM_MODEL, 32'h0, 1'b0},
		'{ACTION_WRITE, SIZE_WORD,      32'h0001_0000, 32'hFFFF_FFFF, FROM_TABLE, 32'h0, 1'b1},
		'{ACTION_READ,  SIZE_BYTE,      32'hFFFF_FFFF, 32'h0000_0000, FROM_TABLE, 32'h0, 1'b1},
		'{ACTION_READ,  SIZE_WORD,      32'hFFFF_FFFE, 32'h0000_0000, FROM_TABLE, 32'h0, 1'b1},
		'{ACTION_WRITE, SIZE_UNDEFINED, 32'hFFFF_FFFD, 32'hFFFF_FFFF, FROM_TABLE, 32'h0, 1'b1},
		'{ACTION_READ,  SIZE_BYTE,      32'h8000_0000, 32'h0000_0000, FROM_TABLE, 32'h0, 1'b1},
		'{ACTION_READ,  SIZE_WORD,      32'h0000_FFFC, 32'h0000_0000, FROM_MODEL, 32'h0, 1'b0},
		'{ACTION_WRITE, SIZE_WORD,      32'h0000_7FFE, 32'h0000_0000, FROM_TABLE, 32'h0, 1'b0},
		'{ACTION_READ,  SIZE_HALF,      32'h0000_7FFF, 32'h0000_0000, FROM_MODEL, 32'h0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Shadow copy of the word store and the responses still owed by the block
	logic [31:0] shadow_words [STORE_WORDS];
	rsp_t        expected_rsp [$];

	bit no_idle = 1'b0;
	bit hold_request = 1'b0;
	int idle_cycles = 0;
	int mismatches = 0;
	int read_count = 0;
	int write_count = 0;
	int range_error_count = 0;
	int span_count = 0;

	byte_addressable_word_memory #(
		.MEMORY_BYTES(MEMORY_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	// Clock: 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one access to the shadow store and return the response it should produce
	function automatic rsp_t shadow_access(input req_t item);
		rsp_t        result;
		logic [63:0] past_last;
		logic [31:0] addr;
		int          count;
		int          k;
		result = '0;
		case (item.access_size)
			SIZE_BYTE: count = 1;
			SIZE_HALF: count = 2;
			default: count = 4;
		endcase
		if (item.action == ACTION_WRITE)
			write_count++;
		else
			read_count++;
		// reject any access with a byte at or past the top, without address wrap
		past_last = {32'd0, item.byte_address} + 64'(count);
		if (past_last > 64'(MEMORY_BYTES)) begin
			result.out_of_range = 1'b1;
			range_error_count++;
			return result;
		end
		if (int'(item.byte_address[1:0]) + count > 4)
			span_count++;
		for (k = 0; k < count; k++) begin
			addr = item.byte_address + 32'(k);
			if (item.action == ACTION_WRITE)
				shadow_words[addr[WORD_BITS+1:2]][8 * addr[1:0] +: 8] =
					item.write_value[8 * k +: 8];
			else
				result.read_value[8 * k +: 8] =
					shadow_words[addr[WORD_BITS+1:2]][8 * addr[1:0] +: 8];
		end
		return result;
	endfunction

	// Idle cycles before the next transaction on either side
	function automatic int pick_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, 5);
	endfunction

	// Random access: mostly a small window at each end so reads meet earlier writes
	function automatic req_t random_request();
		req_t        item;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		item.action = 1'($urandom_range(0, 1));
		item.access_size = 2'($urandom_range(0, 3));
		item.write_value = $urandom();
		if (pick < 45)
			item.byte_address = $urandom_range(0, 63);
		else if (pick < 60)
			item.byte_address = MEMORY_BYTES - 1 - $urandom_range(0, 63);
		else if (pick < 80)
			item.byte_address = $urandom_range(0, MEMORY_BYTES - 1);
		else if (pick < 90)
			item.byte_address = MEMORY_BYTES - $urandom_range(1, 8);
		else
			item.byte_address = $urandom();
		return item;
	endfunction

	// Offer one request, hold it until taken, then record the response it owes
	task automatic offer(input req_t item, input logic source, input rsp_t table_rsp);
		rsp_t model_rsp;
		int   gap;
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		model_rsp = shadow_access(item);
		expected_rsp.push_back((source == FROM_TABLE) ? table_rsp : model_rsp);
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Response side: random stalls, plus one long hold-off on request
	initial begin : drain_responses
		int stall;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					rsp_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
		end
	end

	// Compare every response transaction against the oldest one owed
	always @(posedge clk) begin : check_responses
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected response, read_value %h out_of_range %b",
						$time, rsp.read_value, rsp.out_of_range);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.read_value !== want.read_value) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: read_value expected %h actual %h",
							$time, want.read_value, rsp.read_value);
				end
				if (rsp.out_of_range !== want.out_of_range) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: out_of_range expected %b actual %b",
							$time, want.out_of_range, rsp.out_of_range);
				end
			end
		end
	end

	// Count cycles with no transaction on either side
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("%0t: no transaction for %0d cycles, %0d responses outstanding",
			$time, IDLE_LIMIT, expected_rsp.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		req_t item;
		rsp_t want;
		int   i;
		foreach (shadow_words[w])
			shadow_words[w] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the table of directed cases
		for (i = 0; i < DIRECTED_ROWS; i++) begin
			item.action = directed_rows[i].action;
			item.access_size = directed_rows[i].size;
			item.byte_address = directed_rows[i].addr;
			item.write_value = directed_rows[i].data;
			want.read_value = directed_rows[i].read_value;
			want.out_of_range = directed_rows[i].out_of_range;
			offer(item, directed_rows[i].source, want);
		end

		// random traffic, with bursts free of idling
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			no_idle = ((i / 150) % 3 == 2) || (i >= 400 && i < 470);
			// back up the pipeline behind a long response hold-off
			if (i == 400)
				hold_request = 1'b1;
			// drain everything before carrying on
			if (i == 800) begin
				req_valid <= 1'b0;
				@(posedge clk);
				while (expected_rsp.size() != 0)
					@(posedge clk);
			end
			offer(random_request(), FROM_MODEL, '0);
		end
		no_idle = 1'b0;
		req_valid <= 1'b0;

		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d reads and %0d writes, %0d out of range, %0d spanning two words,",
			read_count, write_count, range_error_count, span_count);
		$display("with random stalls on both sides, a %0d-cycle response hold-off and a full drain.",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
